// File: sv/efd_pkg.sv
package efd_pkg;

    localparam int MAX_WINDOW_DEF = 16;
    localparam int POS_W          = 16;
    localparam int CFG_W          = 15;
    localparam int WLEN_W         = 5;
    localparam int CIDX_W         = 2;
    localparam int IDX32_W        = 32;
    localparam int CNT_W          = 16;
    localparam int ACC_W          = 33;
    localparam int DIV_NW         = 36;
    localparam int DIV_DW         = 18;

    localparam logic [CNT_W-1:0] DUR_CAP = '1;

    localparam logic [WLEN_W-1:0] WLEN_RESET  = WLEN_W'(4);
    localparam logic [CFG_W-1:0]  SPREAD_RESET = CFG_W'(128);
    localparam logic [CFG_W-1:0]  KEEP_RESET   = CFG_W'(256);
    localparam logic [CFG_W-1:0]  TENT_RESET   = CFG_W'(384);

    typedef enum logic [CIDX_W-1:0] {
        CFG_WINDOW_LENGTH = 2'd0,
        CFG_START_SPREAD  = 2'd1,
        CFG_KEEP_RADIUS   = 2'd2,
        CFG_TENT_RADIUS   = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPREAD_ACC,
        ST_SPREAD_MUL,
        ST_SPREAD_LIM,
        ST_SPREAD_CMP,
        ST_DIV_CEN,
        ST_RUN_ACC,
        ST_RUN_CMP,
        ST_RUN_ADD,
        ST_DIV_EMIT,
        ST_EMIT_WR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                     start;
        logic signed [DIV_NW-1:0] num;
        logic [DIV_DW-1:0]        den;
    } div_req_t;

endpackage

// File: sv/eye_fixation_detector.sv
// Sequence: a sample passes ST_FINISH back to idle; a full window adds the
//   spread test, an opening fixation the centre division, a long run the run
//   test; a result adds a division, and out_valid rises in the cycle before
//   in_ready. Throughput: one item at a time, set by the serial window walk
//   and the bit-serial dividers; a result also waits for the output register.
// Reset: rst_n clears all control state, registers take their defaults.
module eye_fixation_detector
    import efd_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [POS_W-1:0]  x_pos,
    input  logic signed [POS_W-1:0]  y_pos,
    input  logic                     last_sample,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [POS_W-1:0]  fix_x,
    output logic signed [POS_W-1:0]  fix_y,
    output logic [IDX32_W-1:0]       start_index,
    output logic [CNT_W-1:0]         fix_duration,
    output logic [CNT_W-1:0]         saccade_duration,
    output logic                     closed_by_end,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CIDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);

    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W  = $clog2(MAX_WINDOW);
    localparam int RUN_W  = $clog2(MAX_WINDOW / 2 + 1);
    localparam int S1_W   = POS_W + 1 + $clog2(MAX_WINDOW);
    localparam int S2_W   = 2 * POS_W - 1 + $clog2(MAX_WINDOW);
    localparam int CMP_W  = 2 * POS_W + 2 * $clog2(MAX_WINDOW);
    localparam int LC_W   = LEN_W + CFG_W;

    // Control and configuration
    state_t                   state_reg, state_next;
    logic [WLEN_W-1:0]        wl_reg, wl_next;
    logic [CFG_W-1:0]         spread_reg, spread_next;
    logic [CFG_W-1:0]         keep_reg, keep_next;
    logic [CFG_W-1:0]         tent_reg, tent_next;
    logic [LEN_W-1:0]         fill_reg, fill_next;
    logic                     in_fix_reg, in_fix_next;
    logic [RUN_W-1:0]         run_reg, run_next;
    logic [IDX32_W-1:0]       sidx_reg, sidx_next;
    logic [CNT_W-1:0]         sacc_reg, sacc_next;
    logic [CNT_W-1:0]         dur_reg, dur_next;
    logic [CNT_W-1:0]         tcnt_reg, tcnt_next;
    logic                     last_reg, last_next;
    logic                     res_reg, res_next;
    logic                     by_end_reg, by_end_next;
    logic [IDX_W-1:0]         i_reg, i_next;
    logic                     out_valid_reg, out_valid_next;

    // Data path
    logic signed [POS_W-1:0]  cen_x_reg, cen_x_next, cen_y_reg, cen_y_next;
    logic signed [ACC_W-1:0]  acc_x_reg, acc_x_next, acc_y_reg, acc_y_next;
    logic signed [ACC_W-1:0]  ten_x_reg, ten_x_next, ten_y_reg, ten_y_next;
    logic [IDX32_W-1:0]       fstart_reg, fstart_next;
    logic [IDX32_W-1:0]       idx_reg, idx_next;
    logic signed [S1_W-1:0]   s1x_reg, s1x_next, s1y_reg, s1y_next;
    logic [S2_W-1:0]          s2x_reg, s2x_next, s2y_reg, s2y_next;
    logic signed [S1_W-1:0]   rcx_reg, rcx_next, rcy_reg, rcy_next;
    logic signed [S1_W-1:0]   rk_reg, rk_next;
    logic [CMP_W-1:0]         p1x_reg, p1x_next, p1y_reg, p1y_next;
    logic [CMP_W-1:0]         p2x_reg, p2x_next, p2y_reg, p2y_next;
    logic [LC_W-1:0]          lc_reg, lc_next;
    logic [CMP_W-1:0]         lim_reg, lim_next;
    logic signed [POS_W-1:0]  ox_reg, ox_next, oy_reg, oy_next;
    logic [IDX32_W-1:0]       ostart_reg, ostart_next;
    logic [CNT_W-1:0]         odur_reg, odur_next, osacc_reg, osacc_next;
    logic                     oend_reg, oend_next;

    // Combinational helpers
    logic [LEN_W-1:0]         len;
    logic [RUN_W-1:0]         runlim;
    logic                     accept_in;
    logic                     shift_en;
    logic signed [POS_W-1:0]  x_rd, y_rd;
    logic signed [2*POS_W-1:0] sqx, sqy;
    logic signed [POS_W:0]    dxs, dys;
    logic [POS_W:0]           dxa, dya;
    logic                     keep_ok, tent_ok;
    logic [LEN_W-1:0]         fill_inc;
    logic [RUN_W-1:0]         run_inc;
    logic signed [ACC_W-1:0]  base_x, base_y;
    logic [CNT_W-1:0]         base_cnt;
    logic signed [CMP_W-1:0]  s1xe, s1ye;
    logic signed [S1_W:0]     ex, ey;
    logic [S1_W:0]            exa, eya;
    logic                     okx, oky;
    div_req_t                 req_x, req_y;
    logic                     done_x, done_y;
    logic signed [DIV_NW-1:0] quot_x, quot_y;

    assign accept_in = in_valid && in_ready;
    assign shift_en  = accept_in;
    assign in_ready  = (state_reg == ST_IDLE);
    // Take a register write only while idle with no sample offered.
    assign cfg_ready = (state_reg == ST_IDLE) && !in_valid;

    // Clamp the window length into [2, MAX_WINDOW]; the run limit is half.
    always_comb
    begin
        if (int'(wl_reg) < 2)
            len = LEN_W'(2);
        else if (int'(wl_reg) > MAX_WINDOW)
            len = LEN_W'(MAX_WINDOW);
        else
            len = LEN_W'(wl_reg);
        runlim = RUN_W'(len >> 1);
    end

    efd_window #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_window (
        .clk      (clk),
        .shift_en (shift_en),
        .x_in     (x_pos),
        .y_in     (y_pos),
        .rd_idx   (i_reg),
        .x_out    (x_rd),
        .y_out    (y_rd)
    );

    efd_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_x),
        .done  (done_x),
        .quot  (quot_x)
    );

    efd_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_y),
        .done  (done_y),
        .quot  (quot_y)
    );

    // Distance tests of an incoming sample against the fixation center, and window-walk helpers.
    always_comb
    begin
        dxs     = {cen_x_reg[POS_W-1], cen_x_reg} - {x_pos[POS_W-1], x_pos};
        dys     = {cen_y_reg[POS_W-1], cen_y_reg} - {y_pos[POS_W-1], y_pos};
        dxa     = dxs[POS_W] ? $unsigned(-dxs) : $unsigned(dxs);
        dya     = dys[POS_W] ? $unsigned(-dys) : $unsigned(dys);
        keep_ok = (dxa <= (POS_W+1)'(keep_reg)) && (dya <= (POS_W+1)'(keep_reg));
        tent_ok = (dxa <= (POS_W+1)'(tent_reg)) && (dya <= (POS_W+1)'(tent_reg));
        fill_inc = (fill_reg == LEN_W'(MAX_WINDOW)) ? fill_reg : fill_reg + LEN_W'(1);
        run_inc  = run_reg + RUN_W'(1);
        sqx  = x_rd * x_rd;
        sqy  = y_rd * y_rd;
        s1xe = CMP_W'(s1x_reg);
        s1ye = CMP_W'(s1y_reg);
        ex   = {s1x_reg[S1_W-1], s1x_reg} - {rcx_reg[S1_W-1], rcx_reg};
        ey   = {s1y_reg[S1_W-1], s1y_reg} - {rcy_reg[S1_W-1], rcy_reg};
        exa  = ex[S1_W] ? $unsigned(-ex) : $unsigned(ex);
        eya  = ey[S1_W] ? $unsigned(-ey) : $unsigned(ey);
        okx  = (p1x_reg - p2x_reg) < lim_reg;
        oky  = (p1y_reg - p2y_reg) < lim_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        wl_next        = wl_reg;
        spread_next    = spread_reg;
        keep_next      = keep_reg;
        tent_next      = tent_reg;
        fill_next      = fill_reg;
        in_fix_next    = in_fix_reg;
        run_next       = run_reg;
        sidx_next      = sidx_reg;
        sacc_next      = sacc_reg;
        dur_next       = dur_reg;
        tcnt_next      = tcnt_reg;
        last_next      = last_reg;
        res_next       = res_reg;
        by_end_next    = by_end_reg;
        i_next         = i_reg;
        cen_x_next     = cen_x_reg;
        cen_y_next     = cen_y_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        ten_x_next     = ten_x_reg;
        ten_y_next     = ten_y_reg;
        fstart_next    = fstart_reg;
        idx_next       = idx_reg;
        s1x_next       = s1x_reg;
        s1y_next       = s1y_reg;
        s2x_next       = s2x_reg;
        s2y_next       = s2y_reg;
        rcx_next       = rcx_reg;
        rcy_next       = rcy_reg;
        rk_next        = rk_reg;
        p1x_next       = p1x_reg;
        p1y_next       = p1y_reg;
        p2x_next       = p2x_reg;
        p2y_next       = p2y_reg;
        lc_next        = lc_reg;
        lim_next       = lim_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        ostart_next    = ostart_reg;
        odur_next      = odur_reg;
        osacc_next     = osacc_reg;
        oend_next      = oend_reg;
        out_valid_next = out_valid_reg && !out_ready;
        base_x         = acc_x_reg;
        base_y         = acc_y_reg;
        base_cnt       = dur_reg;
        req_x          = '0;
        req_y          = '0;

        // Configuration writes land only while idle.
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_WINDOW_LENGTH: wl_next     = cfg_data[WLEN_W-1:0];
                CFG_START_SPREAD:  spread_next = cfg_data;
                CFG_KEEP_RADIUS:   keep_next   = cfg_data;
                CFG_TENT_RADIUS:   tent_next   = cfg_data;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    last_next  = last_sample;
                    res_next   = 1'b0;
                    idx_next   = sidx_reg;
                    sidx_next  = sidx_reg + IDX32_W'(1);
                    state_next = ST_FINISH;
                    if (!in_fix_reg)
                    begin
                        fill_next = fill_inc;
                        if (fill_inc >= len)
                        begin
                            i_next     = '0;
                            s1x_next   = '0;
                            s1y_next   = '0;
                            s2x_next   = '0;
                            s2y_next   = '0;
                            state_next = ST_SPREAD_ACC;
                        end
                    end
                    else if (keep_ok)
                    begin
                        // Return after outliers: parked samples join first.
                        if (run_reg != '0)
                        begin
                            base_x   = ten_x_reg;
                            base_y   = ten_y_reg;
                            base_cnt = tcnt_reg;
                        end
                        acc_x_next = base_x;
                        acc_y_next = base_y;
                        dur_next   = base_cnt;
                        if (base_cnt != DUR_CAP)
                        begin
                            acc_x_next = base_x + ACC_W'(x_pos);
                            acc_y_next = base_y + ACC_W'(y_pos);
                            dur_next   = base_cnt + CNT_W'(1);
                        end
                        ten_x_next = acc_x_next;
                        ten_y_next = acc_y_next;
                        tcnt_next  = dur_next;
                        run_next   = '0;
                    end
                    else
                    begin
                        run_next = run_inc;
                        if (tent_ok && tcnt_reg != DUR_CAP)
                        begin
                            ten_x_next = ten_x_reg + ACC_W'(x_pos);
                            ten_y_next = ten_y_reg + ACC_W'(y_pos);
                            tcnt_next  = tcnt_reg + CNT_W'(1);
                        end
                        if (run_inc >= runlim)
                        begin
                            i_next     = '0;
                            s1x_next   = '0;
                            s1y_next   = '0;
                            rcx_next   = '0;
                            rcy_next   = '0;
                            rk_next    = '0;
                            state_next = ST_RUN_ACC;
                        end
                    end
                end
            end

            ST_SPREAD_ACC:
            begin
                s1x_next = s1x_reg + S1_W'(x_rd);
                s1y_next = s1y_reg + S1_W'(y_rd);
                s2x_next = s2x_reg + S2_W'($unsigned(sqx));
                s2y_next = s2y_reg + S2_W'($unsigned(sqy));
                i_next   = i_reg + IDX_W'(1);
                if (LEN_W'(i_reg) + LEN_W'(1) == len)
                    state_next = ST_SPREAD_MUL;
            end

            ST_SPREAD_MUL:
            begin
                p1x_next   = CMP_W'(s2x_reg) * CMP_W'(len);
                p1y_next   = CMP_W'(s2y_reg) * CMP_W'(len);
                p2x_next   = $unsigned(s1xe * s1xe);
                p2y_next   = $unsigned(s1ye * s1ye);
                lc_next    = LC_W'(len) * LC_W'(spread_reg);
                state_next = ST_SPREAD_LIM;
            end

            ST_SPREAD_LIM:
            begin
                lim_next   = CMP_W'(lc_reg) * CMP_W'(lc_reg);
                state_next = ST_SPREAD_CMP;
            end

            ST_SPREAD_CMP:
            begin
                if (okx && oky)
                begin
                    // Open: the window becomes the accepted set.
                    in_fix_next = 1'b1;
                    fstart_next = idx_reg - IDX32_W'(len) + IDX32_W'(1);
                    acc_x_next  = ACC_W'(s1x_reg);
                    acc_y_next  = ACC_W'(s1y_reg);
                    dur_next    = CNT_W'(len);
                    ten_x_next  = ACC_W'(s1x_reg);
                    ten_y_next  = ACC_W'(s1y_reg);
                    tcnt_next   = CNT_W'(len);
                    run_next    = '0;
                    req_x.start = 1'b1;
                    req_x.num   = (DIV_NW'(s1x_reg) <<< 1) + $signed(DIV_NW'(len));
                    req_x.den   = DIV_DW'(len) << 1;
                    req_y.start = 1'b1;
                    req_y.num   = (DIV_NW'(s1y_reg) <<< 1) + $signed(DIV_NW'(len));
                    req_y.den   = DIV_DW'(len) << 1;
                    state_next  = ST_DIV_CEN;
                end
                else
                begin
                    if (sacc_reg != DUR_CAP)
                        sacc_next = sacc_reg + CNT_W'(1);
                    state_next = ST_FINISH;
                end
            end

            ST_DIV_CEN:
            begin
                if (done_x && done_y)
                begin
                    cen_x_next = quot_x[POS_W-1:0];
                    cen_y_next = quot_y[POS_W-1:0];
                    state_next = ST_FINISH;
                end
            end

            ST_RUN_ACC:
            begin
                s1x_next = s1x_reg + S1_W'(x_rd);
                s1y_next = s1y_reg + S1_W'(y_rd);
                rcx_next = rcx_reg + S1_W'(cen_x_reg);
                rcy_next = rcy_reg + S1_W'(cen_y_reg);
                rk_next  = rk_reg + $signed(S1_W'(keep_reg));
                i_next   = i_reg + IDX_W'(1);
                if (LEN_W'(i_reg) + LEN_W'(1) == LEN_W'(runlim))
                    state_next = ST_RUN_CMP;
            end

            ST_RUN_CMP:
            begin
                if (exa <= (S1_W+1)'($unsigned(rk_reg)) &&
                    eya <= (S1_W+1)'($unsigned(rk_reg)))
                begin
                    i_next     = IDX_W'(runlim - RUN_W'(1));
                    state_next = ST_RUN_ADD;
                end
                else
                begin
                    by_end_next = 1'b0;
                    req_x.start = 1'b1;
                    req_x.num   = (DIV_NW'(acc_x_reg) <<< 1) + $signed(DIV_NW'(dur_reg));
                    req_x.den   = DIV_DW'(dur_reg) << 1;
                    req_y.start = 1'b1;
                    req_y.num   = (DIV_NW'(acc_y_reg) <<< 1) + $signed(DIV_NW'(dur_reg));
                    req_y.den   = DIV_DW'(dur_reg) << 1;
                    state_next  = ST_DIV_EMIT;
                end
            end

            ST_RUN_ADD:
            begin
                // Oldest run sample first, so the cap drops the newest ones.
                if (dur_reg != DUR_CAP)
                begin
                    acc_x_next = acc_x_reg + ACC_W'(x_rd);
                    acc_y_next = acc_y_reg + ACC_W'(y_rd);
                    dur_next   = dur_reg + CNT_W'(1);
                end
                i_next = i_reg - IDX_W'(1);
                if (i_reg == '0)
                begin
                    ten_x_next = acc_x_next;
                    ten_y_next = acc_y_next;
                    tcnt_next  = dur_next;
                    run_next   = '0;
                    state_next = ST_FINISH;
                end
            end

            ST_DIV_EMIT:
            begin
                if (done_x && done_y)
                    state_next = ST_EMIT_WR;
            end

            ST_EMIT_WR:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    ox_next        = (dur_reg == '0) ? '0 : quot_x[POS_W-1:0];
                    oy_next        = (dur_reg == '0) ? '0 : quot_y[POS_W-1:0];
                    ostart_next    = fstart_reg;
                    odur_next      = dur_reg;
                    osacc_next     = sacc_reg;
                    oend_next      = by_end_reg;
                    out_valid_next = 1'b1;
                    res_next       = 1'b1;
                    if (!by_end_reg)
                    begin
                        in_fix_next = 1'b0;
                        fill_next   = LEN_W'(1);
                        sacc_next   = '0;
                        run_next    = '0;
                    end
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (last_reg && in_fix_reg && !res_reg)
                begin
                    by_end_next = 1'b1;
                    req_x.start = 1'b1;
                    req_x.num   = (DIV_NW'(acc_x_reg) <<< 1) + $signed(DIV_NW'(dur_reg));
                    req_x.den   = DIV_DW'(dur_reg) << 1;
                    req_y.start = 1'b1;
                    req_y.num   = (DIV_NW'(acc_y_reg) <<< 1) + $signed(DIV_NW'(dur_reg));
                    req_y.den   = DIV_DW'(dur_reg) << 1;
                    state_next  = ST_DIV_EMIT;
                end
                else
                begin
                    if (last_reg)
                    begin
                        // End of recording: drop all stream state.
                        fill_next   = '0;
                        in_fix_next = 1'b0;
                        cen_x_next  = '0;
                        cen_y_next  = '0;
                        acc_x_next  = '0;
                        acc_y_next  = '0;
                        dur_next    = '0;
                        ten_x_next  = '0;
                        ten_y_next  = '0;
                        tcnt_next   = '0;
                        run_next    = '0;
                        sidx_next   = '0;
                        sacc_next   = '0;
                        fstart_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wl_reg        <= WLEN_RESET;
            spread_reg    <= SPREAD_RESET;
            keep_reg      <= KEEP_RESET;
            tent_reg      <= TENT_RESET;
            fill_reg      <= '0;
            in_fix_reg    <= 1'b0;
            run_reg       <= '0;
            sidx_reg      <= '0;
            sacc_reg      <= '0;
            dur_reg       <= '0;
            tcnt_reg      <= '0;
            last_reg      <= 1'b0;
            res_reg       <= 1'b0;
            by_end_reg    <= 1'b0;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
            cen_x_reg     <= '0;
            cen_y_reg     <= '0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            ten_x_reg     <= '0;
            ten_y_reg     <= '0;
            fstart_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wl_reg        <= wl_next;
            spread_reg    <= spread_next;
            keep_reg      <= keep_next;
            tent_reg      <= tent_next;
            fill_reg      <= fill_next;
            in_fix_reg    <= in_fix_next;
            run_reg       <= run_next;
            sidx_reg      <= sidx_next;
            sacc_reg      <= sacc_next;
            dur_reg       <= dur_next;
            tcnt_reg      <= tcnt_next;
            last_reg      <= last_next;
            res_reg       <= res_next;
            by_end_reg    <= by_end_next;
            i_reg         <= i_next;
            out_valid_reg <= out_valid_next;
            cen_x_reg     <= cen_x_next;
            cen_y_reg     <= cen_y_next;
            acc_x_reg     <= acc_x_next;
            acc_y_reg     <= acc_y_next;
            ten_x_reg     <= ten_x_next;
            ten_y_reg     <= ten_y_next;
            fstart_reg    <= fstart_next;
        end
    end

    // Work registers and the output transaction payload
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        s1x_reg    <= s1x_next;
        s1y_reg    <= s1y_next;
        s2x_reg    <= s2x_next;
        s2y_reg    <= s2y_next;
        rcx_reg    <= rcx_next;
        rcy_reg    <= rcy_next;
        rk_reg     <= rk_next;
        p1x_reg    <= p1x_next;
        p1y_reg    <= p1y_next;
        p2x_reg    <= p2x_next;
        p2y_reg    <= p2y_next;
        lc_reg     <= lc_next;
        lim_reg    <= lim_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        ostart_reg <= ostart_next;
        odur_reg   <= odur_next;
        osacc_reg  <= osacc_next;
        oend_reg   <= oend_next;
    end

    assign out_valid        = out_valid_reg;
    assign fix_x            = ox_reg;
    assign fix_y            = oy_reg;
    assign start_index      = ostart_reg;
    assign fix_duration     = odur_reg;
    assign saccade_duration = osacc_reg;
    assign closed_by_end    = oend_reg;

endmodule

// File: sv/efd_div.sv
// Bit-serial restoring divider, floor quotient of a signed numerator by a
// non-negative denominator. One quotient bit per cycle.
module efd_div
    import efd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  div_req_t                 req,
    output logic                     done,
    output logic signed [DIV_NW-1:0] quot
);

    localparam int CW = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] a_reg, a_next;
    logic [DIV_DW:0]   rem_reg, rem_next;
    logic [DIV_DW-1:0] den_reg, den_next;
    logic              neg_reg, neg_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_DW:0]   shifted;
    logic [DIV_DW+1:0] trial;

    always_comb
    begin
        a_next    = a_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[DIV_DW-1:0], a_reg[DIV_NW-1]};
        trial     = {1'b0, shifted} - {2'b00, den_reg};
        if (req.start)
        begin
            // floor(n/d) for n < 0 is ~((~n)/d)
            neg_next  = req.num[DIV_NW-1];
            a_next    = req.num[DIV_NW-1] ? ~req.num : req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = CW'(DIV_NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_DW+1])
            begin
                rem_next = trial[DIV_DW:0];
                a_next   = {a_reg[DIV_NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                a_next   = {a_reg[DIV_NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? $signed(~a_reg) : $signed(a_reg);

endmodule

// File: sv/efd_window.sv
// Sample shift line with one indexed read tap.
module efd_window
    import efd_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    localparam int IDX_W = $clog2(MAX_WINDOW)
)
(
    input  logic                    clk,
    input  logic                    shift_en,
    input  logic signed [POS_W-1:0] x_in,
    input  logic signed [POS_W-1:0] y_in,
    input  logic [IDX_W-1:0]        rd_idx,
    output logic signed [POS_W-1:0] x_out,
    output logic signed [POS_W-1:0] y_out
);

    logic signed [POS_W-1:0] wx_reg [MAX_WINDOW];
    logic signed [POS_W-1:0] wy_reg [MAX_WINDOW];

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            wx_reg[0] <= x_in;
            wy_reg[0] <= y_in;
            for (int i = 1; i < MAX_WINDOW; i++)
            begin
                wx_reg[i] <= wx_reg[i-1];
                wy_reg[i] <= wy_reg[i-1];
            end
        end
    end

    assign x_out = wx_reg[rd_idx];
    assign y_out = wy_reg[rd_idx];

endmodule

// File: sv/efd_checker.sv
module efd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] fix_x,
    input logic [15:0] fix_duration
);

    // Hold a stalled result transaction.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fix_x))
        else $error("result changed while stalled");

    // Not ready in the cycle after an input transaction.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on back-to-back cycles");

    // A fixation always holds accepted samples.
    a_dur: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fix_duration != 16'd0)
        else $error("empty fixation reported");

endmodule

bind eye_fixation_detector efd_checker u_efd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .fix_x        (fix_x),
    .fix_duration (fix_duration)
);

// File: test/eye_fixation_detector_test.sv
`timescale 1ns / 100ps

module eye_fixation_detector_test;
    import efd_pkg::*;

    typedef struct {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic                    last;
    } gaze_t;

    typedef struct {
        logic signed [POS_W-1:0] fx;
        logic signed [POS_W-1:0] fy;
        logic [IDX32_W-1:0]      start;
        logic [CNT_W-1:0]        dur;
        logic [CNT_W-1:0]        sacc;
        logic                    by_end;
    } fixation_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic                    last_sample;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [POS_W-1:0] fix_x;
    logic signed [POS_W-1:0] fix_y;
    logic [IDX32_W-1:0]      start_index;
    logic [CNT_W-1:0]        fix_duration;
    logic [CNT_W-1:0]        saccade_duration;
    logic                    closed_by_end;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CIDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]        cfg_data;

    eye_fixation_detector i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .x_pos            (x_pos),
        .y_pos            (y_pos),
        .last_sample      (last_sample),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .fix_x            (fix_x),
        .fix_y            (fix_y),
        .start_index      (start_index),
        .fix_duration     (fix_duration),
        .saccade_duration (saccade_duration),
        .closed_by_end    (closed_by_end),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // Generate a 12 ns clock.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    gaze_t     gaze_queue[$];
    fixation_t fixation_queue[$];
    int        errors = 0;

    // Predictor state: register copies and the detector's stream state.
    logic [WLEN_W-1:0] win_len_reg;
    logic [CFG_W-1:0]  spread_reg;
    logic [CFG_W-1:0]  keep_reg;
    logic [CFG_W-1:0]  tent_reg;

    int          win_x[MAX_WINDOW_DEF];
    int          win_y[MAX_WINDOW_DEF];
    int unsigned win_fill;
    bit          fixating;
    int          center_x;
    int          center_y;
    longint      sum_x;
    longint      sum_y;
    int unsigned accepted;
    longint      park_x;
    longint      park_y;
    int unsigned parked;
    int unsigned run_len;
    int unsigned sample_cnt;
    int unsigned saccade_cnt;
    int unsigned fix_begin;

    function automatic void clear_stream();
        for (int i = 0; i < MAX_WINDOW_DEF; i++)
        begin
            win_x[i] = 0;
            win_y[i] = 0;
        end
        win_fill    = 0;
        fixating    = 0;
        center_x    = 0;
        center_y    = 0;
        sum_x       = 0;
        sum_y       = 0;
        accepted    = 0;
        park_x      = 0;
        park_y      = 0;
        parked      = 0;
        run_len     = 0;
        sample_cnt  = 0;
        saccade_cnt = 0;
        fix_begin   = 0;
    endfunction

    function automatic longint floor_quot(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q--;
        return q;
    endfunction

    function automatic longint round_mean(longint n, longint d);
        return floor_quot(2 * n + d, 2 * d);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Variance test without square root, on the newest len samples.
    function automatic bit spread_small(bit use_y, int unsigned len, output int mean);
        longint s1, s2, c, l, v;
        s1 = 0;
        s2 = 0;
        c  = spread_reg;
        l  = len;
        for (int i = 0; i < len; i++)
        begin
            v = use_y ? win_y[i] : win_x[i];
            s1 += v;
            s2 += v * v;
        end
        mean = int'(round_mean(s1, l));
        return l * s2 - s1 * s1 < l * l * c * c;
    endfunction

    function automatic void take_sample(int x, int y);
        if (accepted < 65535)
        begin
            sum_x += x;
            sum_y += y;
            accepted++;
        end
    endfunction

    function automatic void commit_parked();
        park_x = sum_x;
        park_y = sum_y;
        parked = accepted;
    endfunction

    function automatic fixation_t close_fixation(bit by_end);
        fixation_t f;
        longint    d;
        d        = accepted;
        f.fx     = POS_W'(d != 0 ? round_mean(sum_x, d) : 0);
        f.fy     = POS_W'(d != 0 ? round_mean(sum_y, d) : 0);
        f.start  = fix_begin;
        f.dur    = CNT_W'(accepted);
        f.sacc   = CNT_W'(saccade_cnt);
        f.by_end = by_end;
        return f;
    endfunction

    // Advance the detector by one gaze sample; return 1 when a fixation closes.
    function automatic bit detect_step(gaze_t g, output fixation_t f);
        int          sx, sy, mx, my;
        int unsigned len, rlim, idx;
        bit          got, okx, oky;
        longint      dx, dy, kr, tr, rx, ry, r;
        sx   = g.x;
        sy   = g.y;
        got  = 0;
        len  = win_len_reg;
        if (len < 2)
            len = 2;
        if (len > MAX_WINDOW_DEF)
            len = MAX_WINDOW_DEF;
        rlim = len / 2;
        for (int i = MAX_WINDOW_DEF - 1; i > 0; i--)
        begin
            win_x[i] = win_x[i-1];
            win_y[i] = win_y[i-1];
        end
        win_x[0] = sx;
        win_y[0] = sy;
        idx = sample_cnt;
        sample_cnt++;
        if (!fixating)
        begin
            if (win_fill < MAX_WINDOW_DEF)
                win_fill++;
            if (win_fill >= len)
            begin
                okx = spread_small(0, len, mx);
                oky = spread_small(1, len, my);
                if (okx && oky)
                begin
                    fixating  = 1;
                    fix_begin = idx - (len - 1);
                    center_x  = mx;
                    center_y  = my;
                    sum_x     = 0;
                    sum_y     = 0;
                    accepted  = 0;
                    for (int i = 0; i < len; i++)
                        take_sample(win_x[i], win_y[i]);
                    commit_parked();
                    run_len = 0;
                end
                else if (saccade_cnt < 65535)
                    saccade_cnt++;
            end
        end
        else
        begin
            dx = mag(longint'(center_x) - sx);
            dy = mag(longint'(center_y) - sy);
            kr = keep_reg;
            tr = tent_reg;
            if (dx <= kr && dy <= kr)
            begin
                // Return after outliers: parked samples join the fixation.
                if (run_len > 0)
                begin
                    sum_x    = park_x;
                    sum_y    = park_y;
                    accepted = parked;
                end
                take_sample(sx, sy);
                commit_parked();
                run_len = 0;
            end
            else
            begin
                if (run_len < 65535)
                    run_len++;
                if (dx <= tr && dy <= tr && parked < 65535)
                begin
                    park_x += sx;
                    park_y += sy;
                    parked++;
                end
                if (run_len >= rlim)
                begin
                    rx = 0;
                    ry = 0;
                    r  = rlim;
                    for (int i = 0; i < rlim; i++)
                    begin
                        rx += win_x[i];
                        ry += win_y[i];
                    end
                    if (mag(rx - r * center_x) <= r * kr && mag(ry - r * center_y) <= r * kr)
                    begin
                        for (int i = rlim; i > 0; i--)
                            take_sample(win_x[i-1], win_y[i-1]);
                        commit_parked();
                        run_len = 0;
                    end
                    else
                    begin
                        f           = close_fixation(0);
                        got         = 1;
                        fixating    = 0;
                        win_fill    = 1;
                        saccade_cnt = 0;
                        run_len     = 0;
                    end
                end
            end
        end
        if (g.last)
        begin
            if (fixating && !got)
            begin
                f   = close_fixation(1);
                got = 1;
            end
            clear_stream();
        end
        return got;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Driver: bursts of random length separated by random gaps.
    gaze_t cur_gaze;
    int    burst_left;
    int    gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        fixation_t f;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            x_pos       <= '0;
            y_pos       <= '0;
            last_sample <= 1'b0;
            burst_left  = 10;
            gap_left    = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (detect_step(cur_gaze, f))
                    fixation_queue.push_back(f);
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (gaze_queue.size() > 0)
                begin
                    cur_gaze    = gaze_queue.pop_front();
                    x_pos       <= cur_gaze.x;
                    y_pos       <= cur_gaze.y;
                    last_sample <= cur_gaze.last;
                    in_valid    <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: receiver stalls follow a mode pattern; compare each transaction.
    int stall_mode;
    int stall_left;

    always @(posedge clk or negedge rst_n)
    begin
        fixation_t e;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_mode = 0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (fixation_queue.size() == 0)
                begin
                    $display("%0t: unexpected fixation transaction", $realtime);
                    errors++;
                end
                else
                begin
                    e = fixation_queue.pop_front();
                    if (fix_x !== e.fx)
                        report("fix_x", fix_x, e.fx);
                    if (fix_y !== e.fy)
                        report("fix_y", fix_y, e.fy);
                    if (start_index !== e.start)
                        report("start_index", start_index, e.start);
                    if (fix_duration !== e.dur)
                        report("fix_duration", fix_duration, e.dur);
                    if (saccade_duration !== e.sacc)
                        report("saccade_duration", saccade_duration, e.sacc);
                    if (closed_by_end !== e.by_end)
                        report("closed_by_end", closed_by_end, e.by_end);
                end
            end
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(5, 60);
            end
            else
                stall_left--;
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= 1'b0;
            endcase
        end
    end

    // Stimulus helpers.
    function automatic void push_gaze(int x, int y, bit last);
        gaze_t g;
        g.x    = POS_W'(x);
        g.y    = POS_W'(y);
        g.last = last;
        gaze_queue.push_back(g);
    endfunction

    function automatic int jitter(int a);
        return int'($urandom_range(0, 2 * a)) - a;
    endfunction

    function automatic int any_pos();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // Build mostly well-formed recordings: fixations, outlier runs, saccades.
    function automatic void make_recording(int n);
        int len, rlim, cx, cy, amp, k, reach, cnt;
        len = win_len_reg < 2 ? 2 : (win_len_reg > MAX_WINDOW_DEF ? MAX_WINDOW_DEF : win_len_reg);
        rlim = len / 2;
        cx   = any_pos();
        cy   = any_pos();
        cnt  = 0;
        while (cnt < n)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    k   = $urandom_range(len, 4 * len);
                    amp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, spread_reg)
                                                      : spread_reg / 2;
                    if (amp > keep_reg && $urandom_range(0, 1) == 1)
                        amp = keep_reg;
                    for (int i = 0; i < k; i++)
                        push_gaze(cx + jitter(amp), cy + jitter(amp), 0);
                    cnt += k;
                end
                5, 6:
                begin
                    k = $urandom_range(1, rlim + 1);
                    for (int i = 0; i < k; i++)
                    begin
                        reach = keep_reg + $urandom_range(1, (tent_reg > keep_reg ?
                                                              tent_reg - keep_reg : 0) + 64);
                        push_gaze(cx + ($urandom_range(0, 1) ? reach : -reach),
                                  cy + jitter(reach), 0);
                    end
                    cnt += k;
                end
                7:
                begin
                    cx = any_pos();
                    cy = any_pos();
                    k  = $urandom_range(1, 3);
                    for (int i = 0; i < k; i++)
                        push_gaze(any_pos(), any_pos(), 0);
                    cnt += k;
                end
                8:
                begin
                    cx += jitter(keep_reg);
                    cy += jitter(keep_reg);
                end
                default:
                begin
                    push_gaze(cx + jitter(spread_reg), cy + jitter(spread_reg),
                              $urandom_range(0, 2) == 0);
                    cnt++;
                end
            endcase
        end
    endfunction

    // Hold until every queued sample is sent and every fixation has come back.
    task automatic drain();
        while (gaze_queue.size() != 0 || in_valid || fixation_queue.size() != 0)
            @(posedge clk);
        // Let a window test or divider finish even when it produces nothing.
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t which, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        // Ready settles between edges; the write lands at the next rising edge.
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        case (which)
            CFG_WINDOW_LENGTH: win_len_reg = value[WLEN_W-1:0];
            CFG_START_SPREAD:  spread_reg  = value;
            CFG_KEEP_RADIUS:   keep_reg    = value;
            default:           tent_reg    = value;
        endcase
    endtask

    task automatic set_all(int wl, int sp, int kr, int tr);
        write_reg(CFG_WINDOW_LENGTH, CFG_W'(wl));
        write_reg(CFG_START_SPREAD, CFG_W'(sp));
        write_reg(CFG_KEEP_RADIUS, CFG_W'(kr));
        write_reg(CFG_TENT_RADIUS, CFG_W'(tr));
    endtask

    initial
    begin
        cfg_valid   = 1'b0;
        cfg_index   = CFG_WINDOW_LENGTH;
        cfg_data    = '0;
        win_len_reg = WLEN_RESET;
        spread_reg  = SPREAD_RESET;
        keep_reg    = KEEP_RESET;
        tent_reg    = TENT_RESET;
        clear_stream();
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part with the reset settings: L = 4, run limit 2.
        for (int i = 0; i < 4; i++)
            push_gaze(0, 0, 0);                 // open on a still window
        push_gaze(300, 0, 0);                   // tentative outlier
        push_gaze(0, 0, 0);                     // return after outliers
        push_gaze(300, 0, 0);
        push_gaze(-300, 0, 0);                  // run accepted, mean on center
        push_gaze(32767, 32767, 0);
        push_gaze(32767, 32767, 0);             // run rejected, fixation closes
        for (int i = 0; i < 4; i++)
            push_gaze(-32768, -32768, 0);
        push_gaze(-32768, -32768, 1);           // closed by end of recording
        push_gaze(32767, -32768, 0);
        push_gaze(-32768, 32767, 1);            // end with no fixation open
        for (int i = 0; i < 4; i++)
            push_gaze(100, -100, i == 3);       // opens and ends on one sample
        drain();

        make_recording(150);
        drain();

        // Extremes and out-of-range window lengths.
        set_all(0, 32767, 32767, 32767);
        make_recording(120);
        drain();
        set_all(31, 200, 300, 200);
        make_recording(150);
        drain();
        set_all(16, 0, 0, 0);
        make_recording(60);
        drain();
        set_all(2, 512, 0, 32767);
        make_recording(150);
        drain();
        set_all(1, 64, 128, 256);
        make_recording(120);
        drain();
        for (int p = 0; p < 3; p++)
        begin
            set_all($urandom_range(2, 16), $urandom_range(16, 1024),
                    $urandom_range(64, 2048), $urandom_range(64, 4096));
            make_recording(120);
            // Lower the window mid-recording so a run can exceed the new limit.
            drain();
            write_reg(CFG_WINDOW_LENGTH, CFG_W'(2));
            make_recording(30);
            drain();
        end
        set_all(17, 32767, 16383, 24575);
        make_recording(40);
        drain();

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #15ms;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
sv/efd_pkg.sv
sv/efd_div.sv
sv/efd_window.sv
sv/eye_fixation_detector.sv
sv/efd_checker.sv
test/eye_fixation_detector_test.sv
